[rtl/core/text_console_writer_macros.svh]
// Assertion helpers shared by the console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, off during reset.
`define TCW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcw: same-cycle check failed");

// Next-cycle implication, off during reset.
`define TCW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcw: next-cycle check failed");

`endif

[rtl/core/tcw_pkg.sv]
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned IDX_W  = 11;

  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0E;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } tcw_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [IDX_W-1:0]  cursor_at;
  } tcw_result_t;

endpackage

[rtl/core/tcw_cell_ram.sv]
`timescale 1ns / 1ps
module tcw_cell_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [tcw_pkg::CELL_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [tcw_pkg::CELL_W-1:0] rdata_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tcw_engine.sv]
`timescale 1ns / 1ps
module tcw_engine #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned LINES   = 25
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       item_valid_i,
  output logic                       item_ready_o,
  input  tcw_pkg::tcw_item_t         item_i,
  input  logic [tcw_pkg::ATTR_W-1:0] attr_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output tcw_pkg::tcw_result_t       res_o
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = COLUMNS * LINES;
  localparam int unsigned AW    = $clog2(CELLS + 1);
  localparam int unsigned RW    = $clog2(CELLS);
  localparam int unsigned CLW   = $clog2(COLUMNS);
  localparam int unsigned XW    = AW + IDX_W;

  localparam logic [AW-1:0]  CELLS_A      = AW'(CELLS);
  localparam logic [AW-1:0]  LAST_CELL_A  = AW'(CELLS - 1);
  localparam logic [AW-1:0]  LAST_LINE_A  = AW'(COLUMNS * (LINES - 1));
  localparam logic [AW-1:0]  COLUMNS_A    = AW'(COLUMNS);
  localparam logic [CLW-1:0] COL_LAST     = CLW'(COLUMNS - 1);
  localparam logic [XW-1:0]  CELLS_X      = XW'(CELLS);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_RDW, ST_TAB, ST_CLR, ST_SCR, ST_SCR_TAIL, ST_DONE
  } state_e;

  state_e            state_q;
  logic [AW-1:0]     cursor_q;
  logic [CLW-1:0]    col_q;
  logic [AW-1:0]     ptr_q;
  logic [CLW-1:0]    pcol_q;
  logic [RW-1:0]     wa_q;
  logic              pend_q;
  logic [CELL_W-1:0] data_q;

  logic              ram_we;
  logic [RW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [RW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic [AW-1:0]     cur_f;
  logic [CLW-1:0]    col_f;
  logic [CLW-1:0]    col_f_nxt;
  logic [CLW-1:0]    col_q_nxt;
  logic [XW-1:0]     idx_x;
  logic [XW-1:0]     cur_x;
  logic              idx_ok;
  logic              plain;
  logic              do_put;

  // Park a cursor beyond the last cell at the head of the last line.
  assign cur_f     = (cursor_q >= CELLS_A) ? LAST_LINE_A : cursor_q;
  assign col_f     = (cursor_q >= CELLS_A) ? '0 : col_q;
  assign col_f_nxt = (col_f == COL_LAST) ? '0 : col_f + 1'b1;
  assign col_q_nxt = (col_q == COL_LAST) ? '0 : col_q + 1'b1;
  assign idx_x     = XW'(item_i.cell_index);
  assign cur_x     = XW'(cursor_q);
  assign idx_ok    = idx_x < CELLS_X;
  assign plain     = (item_i.char_code != CH_TAB) && (item_i.char_code != CH_BACKSPACE) &&
                     (item_i.char_code != CH_RETURN) && (item_i.char_code != CH_NEWLINE);
  assign do_put    = (state_q == ST_IDLE) && item_valid_i && (item_i.action == ACT_PUT);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cursor_q[RW-1:0];
    ram_wdata = {attr_i, CH_SPACE};
    ram_raddr = ptr_q[RW-1:0];
    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[RW-1:0];
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_raddr = idx_x[RW-1:0];
        ram_we    = do_put && plain;
        ram_waddr = cur_f[RW-1:0];
        ram_wdata = {attr_i, item_i.char_code};
      end
      ST_TAB: begin
        ram_we = 1'b1;
      end
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[RW-1:0];
        ram_wdata = '0;
      end
      ST_SCR: begin
        ram_we    = pend_q;
        ram_waddr = wa_q;
        ram_wdata = ram_rdata;
      end
      ST_SCR_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = wa_q;
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      cursor_q <= '0;
      col_q    <= '0;
      ptr_q    <= '0;
      pcol_q   <= '0;
      wa_q     <= '0;
      pend_q   <= 1'b0;
      data_q   <= '0;
    end else begin
      case (state_q)
        ST_INIT: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == LAST_CELL_A) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_valid_i) begin
            data_q <= '0;
            if (item_i.action == ACT_READ) begin
              state_q <= idx_ok ? ST_RDW : ST_DONE;
            end else begin
              cursor_q <= cur_f;
              col_q    <= col_f;
              state_q  <= ST_DONE;
              case (item_i.char_code)
                CH_TAB: begin
                  state_q <= ST_TAB;
                end
                CH_BACKSPACE: begin
                  if (cur_f != '0) begin
                    cursor_q <= cur_f - 1'b1;
                    col_q    <= (col_f == '0) ? COL_LAST : col_f - 1'b1;
                  end
                end
                CH_RETURN: begin
                  ptr_q    <= cur_f;
                  pcol_q   <= col_f;
                  cursor_q <= cur_f - AW'(col_f);
                  col_q    <= '0;
                  state_q  <= ST_CLR;
                end
                CH_NEWLINE: begin
                  if (cur_f >= LAST_LINE_A) begin
                    ptr_q   <= COLUMNS_A;
                    pend_q  <= 1'b0;
                    state_q <= ST_SCR;
                  end else begin
                    cursor_q <= cur_f + COLUMNS_A;
                  end
                end
                default: begin
                  cursor_q <= cur_f + 1'b1;
                  col_q    <= col_f_nxt;
                end
              endcase
            end
          end
        end
        ST_RDW: begin
          data_q  <= ram_rdata;
          state_q <= ST_DONE;
        end
        ST_TAB: begin
          cursor_q <= cursor_q + 1'b1;
          col_q    <= col_q_nxt;
          if ((col_q_nxt[2:0] == 3'd0) || (cursor_q == LAST_CELL_A)) begin
            state_q <= ST_DONE;
          end
        end
        ST_CLR: begin
          ptr_q  <= ptr_q + 1'b1;
          pcol_q <= pcol_q + 1'b1;
          if ((pcol_q == COL_LAST) || (ptr_q == LAST_CELL_A)) begin
            state_q <= ST_DONE;
          end
        end
        ST_SCR: begin
          // Read one line ahead, write back in the next cycle.
          wa_q   <= RW'(ptr_q - COLUMNS_A);
          pend_q <= 1'b1;
          ptr_q  <= ptr_q + 1'b1;
          if (ptr_q == LAST_CELL_A) begin
            state_q <= ST_SCR_TAIL;
          end
        end
        ST_SCR_TAIL: begin
          ptr_q   <= LAST_LINE_A;
          pcol_q  <= '0;
          state_q <= ST_CLR;
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign item_ready_o    = (state_q == ST_IDLE);
  assign res_valid_o     = (state_q == ST_DONE);
  assign res_o.cell_data = data_q;
  assign res_o.cursor_at = cur_x[IDX_W-1:0];

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (RW)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

[rtl/core/text_console_writer.sv]
`timescale 1ns / 1ps
// Channel   Dir  Signals                         Contents (low bit up)
// request   in   s_axis_tvalid/tready/tdata/tuser tuser: action; tdata: char_code, cell_index
// result    out  m_axis_tvalid/tready/tdata       tdata: cell_data, cursor_at
// config    in   cfg_we_i/cfg_wdata_i             attribute byte
//
// A read of a screen cell waits on the registered RAM read; a tab writes spaces up to the
// next multiple of eight columns or the screen end; a carriage return clears the rest of
// the line; a scroll moves each line up, one cell a cycle through the single write port
// of the cell RAM, and clears the last line. After reset a clearing pass zeroes the
// screen; no request is taken meanwhile. A new request is taken while a result waits in
// the output register; the engine holds its next result until that register frees.
module text_console_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned LINES   = 25
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,  // char_code, cell_index, pad
  input  logic [0:0]                 s_axis_tuser,  // action
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // cell_data, cursor_at, pad
  input  logic                       cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata_i
);
  import tcw_pkg::*;
  `include "text_console_writer_macros.svh"

  logic [ATTR_W-1:0] attr_q;
  tcw_item_t         item;
  tcw_result_t       res;
  logic              res_valid;
  logic              res_take;
  logic              out_vld_q;
  tcw_result_t       out_q;

  assign item.action     = s_axis_tuser[0];
  assign item.char_code  = s_axis_tdata[CHAR_W-1:0];
  assign item.cell_index = s_axis_tdata[CHAR_W+IDX_W-1:CHAR_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  tcw_engine #(
    .COLUMNS (COLUMNS),
    .LINES   (LINES)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .attr_i       (attr_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_take),
    .res_o        (res)
  );

  // Load the output register when empty or drained this cycle.
  assign res_take = res_valid && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      if (res_take) begin
        out_vld_q <= 1'b1;
        out_q     <= res;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(32 - CELL_W - IDX_W){1'b0}}, out_q.cursor_at, out_q.cell_data};

  `TCW_ASSERT_NXT(a_res_held, clk_i, rst_ni, res_valid && !res_take, res_valid && $stable(res))
  `TCW_ASSERT_IMP(a_no_req_while_res, clk_i, rst_ni, res_valid, !s_axis_tready)
  `TCW_ASSERT_NXT(a_out_kept, clk_i, rst_ni, out_vld_q && !m_axis_tready, out_vld_q && $stable(out_q))

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
  import tcw_pkg::*;

  localparam int unsigned COLS        = 80;
  localparam int unsigned ROWS        = 25;
  localparam int unsigned CELLS       = COLS * ROWS;
  localparam int unsigned LAST_ROW_AT = COLS * (ROWS - 1);

  typedef struct {
    logic              act;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  ix;
    int unsigned       reps;
    bit                typed;
    tcw_result_t       want;
  } keystroke_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata  = '0;
  logic [0:0]         s_axis_tuser  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;
  logic               cfg_we_i      = 1'b0;
  logic [ATTR_W-1:0]  cfg_wdata_i   = '0;

  // Shadow copy of the screen, cursor and colour
  logic [CELL_W-1:0]  shadow_screen [CELLS];
  int unsigned        cur_pos;
  int unsigned        cur_col;
  logic [ATTR_W-1:0]  scr_attr;

  tcw_result_t        screen_replies [$];
  keystroke_t         keystrokes [$];
  int unsigned        sent_count  = 0;
  int unsigned        fault_count = 0;
  int unsigned        stall_left  = 0;
  bit                 gaps_on     = 1'b1;
  bit                 stalls_on   = 1'b1;

  always #2 clk_i = ~clk_i;

  text_console_writer #(
    .COLUMNS(COLS),
    .LINES  (ROWS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  function automatic void lay_cell(logic [CHAR_W-1:0] ch);
    if (cur_pos < CELLS) shadow_screen[cur_pos] = {scr_attr, ch};
    cur_pos++;
    cur_col++;
    if (cur_col >= COLS) cur_col = 0;
  endfunction

  function automatic void console_put(logic [CHAR_W-1:0] ch);
    int unsigned stop;
    if (cur_pos >= CELLS) begin
      cur_pos = LAST_ROW_AT;
      cur_col = 0;
    end
    case (ch)
      CH_TAB: begin
        do lay_cell(CH_SPACE);
        while (cur_col % 8 != 0 && cur_pos < CELLS);
      end
      CH_BACKSPACE: begin
        if (cur_pos > 0) begin
          cur_pos--;
          cur_col = (cur_col == 0) ? COLS - 1 : cur_col - 1;
        end
      end
      CH_RETURN: begin
        stop = cur_pos + COLS - cur_col;
        if (stop > CELLS) stop = CELLS;
        for (int unsigned i = cur_pos; i < stop; i++) shadow_screen[i] = '0;
        cur_pos = (cur_col <= cur_pos) ? cur_pos - cur_col : 0;
        cur_col = 0;
      end
      CH_NEWLINE: begin
        if (cur_pos >= LAST_ROW_AT) begin
          // scroll up one line and blank the last one
          for (int unsigned i = 0; i < LAST_ROW_AT; i++) shadow_screen[i] = shadow_screen[i + COLS];
          for (int unsigned i = LAST_ROW_AT; i < CELLS; i++) shadow_screen[i] = '0;
        end else begin
          cur_pos += COLS;
        end
      end
      default: lay_cell(ch);
    endcase
  endfunction

  function automatic tcw_result_t console_step(logic act, logic [CHAR_W-1:0] ch,
                                               logic [IDX_W-1:0] ix);
    tcw_result_t r;
    r.cell_data = '0;
    if (act == ACT_PUT) begin
      console_put(ch);
    end else if (ix < CELLS) begin
      r.cell_data = shadow_screen[ix];
    end
    r.cursor_at = cur_pos[IDX_W-1:0];
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_glyph();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255));
    while (c == CH_TAB || c == CH_BACKSPACE || c == CH_RETURN || c == CH_NEWLINE);
    return c;
  endfunction

  function automatic keystroke_t stroke(logic act, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] ix,
                                        int unsigned reps, bit typed,
                                        logic [CELL_W-1:0] want_data,
                                        logic [IDX_W-1:0] want_cur);
    keystroke_t k;
    k.act = act;
    k.ch = ch;
    k.ix = ix;
    k.reps = reps;
    k.typed = typed;
    k.want.cell_data = want_data;
    k.want.cursor_at = want_cur;
    return k;
  endfunction

  // Hold the request until taken, then record what the screen should answer
  task automatic send_request(logic act, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] ix,
                              bit typed, tcw_result_t want);
    tcw_result_t forecast;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {5'd0, ix, ch};
    do @(posedge clk_i);
    while (!s_axis_tready);
    forecast = console_step(act, ch, ix);
    screen_replies.push_back(typed ? want : forecast);
    sent_count++;
  endtask

  task automatic put_char(logic [CHAR_W-1:0] ch);
    send_request(ACT_PUT, ch, IDX_W'($urandom_range(0, 2047)), 1'b0, '0);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (screen_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_attribute(logic [ATTR_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    scr_attr = value;
  endtask

  task automatic type_text(int unsigned quota);
    int unsigned goal, back;
    int unsigned kind;
    logic [IDX_W-1:0] ix;
    goal = sent_count + quota;
    while (sent_count < goal) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // one line of text, usually closed by return and line feed
        repeat ($urandom_range(1, 20))
          put_char(($urandom_range(0, 7) == 0) ? CH_TAB : pick_glyph());
        if ($urandom_range(0, 2) != 0) put_char(CH_RETURN);
        if ($urandom_range(0, 3) != 0) put_char(CH_NEWLINE);
      end else if (kind == 4) begin
        // run across line ends and past the end of the screen
        repeat ($urandom_range(10, 25))
          put_char(($urandom_range(0, 2) == 0) ? CH_TAB : pick_glyph());
      end else if (kind <= 6) begin
        repeat ($urandom_range(1, 4)) begin
          back = $urandom_range(0, 120);
          if ($urandom_range(0, 1) == 0) ix = IDX_W'($urandom_range(0, 2047));
          else ix = (cur_pos > back) ? IDX_W'(cur_pos - back) : '0;
          send_request(ACT_READ, CHAR_W'($urandom_range(0, 255)), ix, 1'b0, '0);
        end
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 5)) put_char(CH_BACKSPACE);
        repeat ($urandom_range(0, 4)) put_char(pick_glyph());
      end else begin
        repeat ($urandom_range(1, 5))
          send_request(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                       IDX_W'($urandom_range(0, 2047)), 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    tcw_result_t got;
    tcw_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.cell_data = m_axis_tdata[15:0];
      got.cursor_at = m_axis_tdata[26:16];
      want = '0;
      if (screen_replies.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: unrequested reply data %h cursor %0d", $time, got.cell_data,
                   got.cursor_at);
      end else begin
        want = screen_replies.pop_front();
        if (got.cell_data !== want.cell_data || got.cursor_at !== want.cursor_at) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: expected data %h cursor %0d, got data %h cursor %0d", $time,
                     want.cell_data, want.cursor_at, got.cell_data, got.cursor_at);
        end
      end
    end
  end

  initial begin
    #12_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    for (int unsigned i = 0; i < CELLS; i++) shadow_screen[i] = '0;
    cur_pos = 0;
    cur_col = 0;
    scr_attr = ATTR_RESET;

    keystrokes.push_back(stroke(ACT_READ, 8'h00,        11'd0,    1, 1, 16'h0000, 11'd0));
    keystrokes.push_back(stroke(ACT_READ, 8'h00,        11'd1999, 1, 1, 16'h0000, 11'd0));
    // reads beyond the screen come back blank
    keystrokes.push_back(stroke(ACT_READ, 8'h00,        11'd2047, 1, 1, 16'h0000, 11'd0));
    keystrokes.push_back(stroke(ACT_READ, 8'h00,        11'd2000, 1, 1, 16'h0000, 11'd0));
    keystrokes.push_back(stroke(ACT_PUT,  CH_BACKSPACE, 11'd0,    1, 1, 16'h0000, 11'd0));
    keystrokes.push_back(stroke(ACT_PUT,  8'h41,        11'd0,    1, 1, 16'h0000, 11'd1));
    keystrokes.push_back(stroke(ACT_READ, 8'h00,        11'd0,    1, 1, 16'h0E41, 11'd1));
    keystrokes.push_back(stroke(ACT_PUT,  CH_TAB,       11'd0,    1, 1, 16'h0000, 11'd8));
    keystrokes.push_back(stroke(ACT_READ, 8'h00,        11'd1,    1, 1, 16'h0E20, 11'd8));
    keystrokes.push_back(stroke(ACT_PUT,  8'hFF,        11'd0,    1, 0, '0, '0));
    keystrokes.push_back(stroke(ACT_PUT,  8'h00,        11'd0,    1, 0, '0, '0));
    keystrokes.push_back(stroke(ACT_PUT,  CH_RETURN,    11'd0,    1, 1, 16'h0000, 11'd0));
    // return clears only from the cursor onwards
    keystrokes.push_back(stroke(ACT_READ, 8'h00,        11'd0,    1, 1, 16'h0E41, 11'd0));
    keystrokes.push_back(stroke(ACT_PUT,  CH_NEWLINE,   11'd0,    1, 1, 16'h0000, 11'd80));
    // back over a line start lands on the last column above
    keystrokes.push_back(stroke(ACT_PUT,  CH_BACKSPACE, 11'd0,    1, 1, 16'h0000, 11'd79));
    keystrokes.push_back(stroke(ACT_PUT,  8'h78,        11'd0,    1, 0, '0, '0));
    keystrokes.push_back(stroke(ACT_PUT,  CH_NEWLINE,   11'd0,   23, 0, '0, '0));
    // tabs fill the last line and leave the cursor past the end
    keystrokes.push_back(stroke(ACT_PUT,  CH_TAB,       11'd0,   10, 0, '0, '0));
    keystrokes.push_back(stroke(ACT_READ, 8'h00,        11'd1999, 1, 1, 16'h0E20, 11'd2000));
    keystrokes.push_back(stroke(ACT_PUT,  8'h5A,        11'd0,    1, 1, 16'h0000, 11'd1921));
    keystrokes.push_back(stroke(ACT_PUT,  CH_NEWLINE,   11'd0,    1, 1, 16'h0000, 11'd1921));
    keystrokes.push_back(stroke(ACT_READ, 8'h00,        11'd1920, 1, 1, 16'h0000, 11'd1921));
    keystrokes.push_back(stroke(ACT_READ, 8'h00,        11'd1840, 1, 1, 16'h0E5A, 11'd1921));
    keystrokes.push_back(stroke(ACT_PUT,  CH_RETURN,    11'd0,    1, 1, 16'h0000, 11'd1920));
    keystrokes.push_back(stroke(ACT_PUT,  CH_BACKSPACE, 11'd0,    1, 1, 16'h0000, 11'd1919));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (keystrokes[r])
      repeat (keystrokes[r].reps)
        send_request(keystrokes[r].act, keystrokes[r].ch, keystrokes[r].ix,
                     keystrokes[r].typed, keystrokes[r].want);
    settle();

    // change colour only while nothing is in flight; the last pass runs flat out
    for (int p = 0; p < 4; p++) begin
      set_attribute(p == 0 ? 8'hFF : p == 1 ? 8'h00 : ATTR_W'($urandom_range(1, 254)));
      gaps_on   = (p < 3);
      stalls_on = (p < 3);
      type_text(p < 2 ? 60 : 55);
      settle();
    end

    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
